### rtl/core/flba_pkg.sv
package flba_pkg;

	// Default pool geometry
	localparam int POOL_BLOCKS_DEF  = 256;
	localparam int BLOCK_BYTES_DEF  = 16;
	localparam int HEADER_BYTES_DEF = 8;

	// Field widths of the stream channels
	localparam int BYTES_W = 13;
	localparam int REL_W   = 8;
	localparam int START_W = 8;
	localparam int STAT_W  = 2;

	// Write slots in one update plan
	localparam int NSLOT = 3;

	// Request kinds
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Fit policies
	localparam logic POL_FIRST = 1'b0;
	localparam logic POL_BEST  = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_ALLOC   = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FREED   = 2'd2;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CHK,
		S_SIZE_A,
		S_SIZE_B,
		S_RD,
		S_EVAL,
		S_RD_B,
		S_PLAN,
		S_WR,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic init;
		logic load;
		logic size_a;
		logic size_b;
		logic rd;
		logic eval;
		logic rd_b;
		logic plan;
		logic wr;
		logic result;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_free;
		logic b_out;
		logic walk_go;
		logic hit;
		logic stop;
		logic last_slot;
		logic out_free;
	} sts_t;

endpackage

### rtl/core/free_list_block_allocator_core.sv
// Allocate: decode, size estimate and correction, free-list walk, plan, writes, result.
// Free: decode, walk up to the released block, read of it, plan, writes, result; a block
// out of range or already free gets no plan or writes. A list step reads the length
// and link memories, then evaluates. One request at a time; the next is taken once the
// result is registered. Reset: asynchronous, active low; INIT then writes the initial
// free area at block 0 before requests are taken. fit_policy resets to first fit.
module free_list_block_allocator_core #(
	parameter int POOL_BLOCKS  = flba_pkg::POOL_BLOCKS_DEF,
	parameter int BLOCK_BYTES  = flba_pkg::BLOCK_BYTES_DEF,
	parameter int HEADER_BYTES = flba_pkg::HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,       // fit_policy
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // request_bytes[12:0], release_block[20:13], zero pad
	input  logic        s_axis_tuser,   // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // start_block[7:0]
	output logic [1:0]  m_axis_tuser    // status[1:0]
);

	flba_pkg::cmd_t cmd;
	flba_pkg::sts_t sts;
	logic           fit_policy_q;

	// Policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= flba_pkg::POL_FIRST;
		end else if (cfg_valid) begin
			fit_policy_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	flba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	flba_dp #(
		.POOL_BLOCKS(POOL_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES), .HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts),
		.fit_policy(fit_policy_q),
		.in_action(s_axis_tuser),
		.in_bytes(s_axis_tdata[12:0]),
		.in_release(s_axis_tdata[20:13]),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_start(m_axis_tdata),
		.out_status(m_axis_tuser)
	);

endmodule

### rtl/core/flba_ram.sv
module flba_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/flba_dp.sv
module flba_dp #(
	parameter int POOL_BLOCKS  = flba_pkg::POOL_BLOCKS_DEF,
	parameter int BLOCK_BYTES  = flba_pkg::BLOCK_BYTES_DEF,
	parameter int HEADER_BYTES = flba_pkg::HEADER_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  flba_pkg::cmd_t                cmd,
	output flba_pkg::sts_t                sts,
	input  logic                          fit_policy,
	input  logic                          in_action,
	input  logic [flba_pkg::BYTES_W-1:0]  in_bytes,
	input  logic [flba_pkg::REL_W-1:0]    in_release,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [flba_pkg::START_W-1:0]  out_start,
	output logic [flba_pkg::STAT_W-1:0]   out_status
);

	localparam int IDX_W = $clog2(POOL_BLOCKS);
	localparam int LEN_W = $clog2(POOL_BLOCKS + 1);
	localparam int X_W   = $clog2((1 << flba_pkg::BYTES_W) + HEADER_BYTES + BLOCK_BYTES);
	localparam int B_W   = $clog2(BLOCK_BYTES + 1);
	localparam int AW0   = (X_W > LEN_W) ? X_W : LEN_W;
	localparam int AW1   = (AW0 > flba_pkg::REL_W) ? AW0 : flba_pkg::REL_W;
	localparam int AW    = AW1 + 1;
	localparam int K     = X_W + B_W;
	localparam int M_W   = X_W + 2;
	localparam longint M_L = (64'd1 << K) / BLOCK_BYTES;
	localparam logic [M_W-1:0] RECIP = M_W'(M_L);
	localparam int P_W = X_W + M_W;
	localparam int Q_W = X_W + B_W;
	localparam logic [AW-1:0] POOL_A = AW'(POOL_BLOCKS);
	localparam logic [LEN_W-1:0] POOL_L = LEN_W'(POOL_BLOCKS);
	localparam int SL_W = $clog2(flba_pkg::NSLOT);

	// Request registers
	logic                 act_q;
	logic [X_W-1:0]       x_q;
	logic [flba_pkg::REL_W-1:0] rel_q;
	logic [X_W-1:0]       q0_s1;
	logic [X_W-1:0]       n_q;

	// Walk registers
	logic [LEN_W-1:0] cur_q, prev_q, curnxt_q, head_q;
	logic [LEN_W-1:0] plen_q, curlen_q;
	logic [LEN_W-1:0] steps_q;
	logic             hp_q, hasnx_q;

	// Chosen area
	logic             found_q, sel_hp_q;
	logic [LEN_W-1:0] sel_cur_q, sel_prev_q, sel_len_q, sel_nxt_q;

	// Update plan
	logic             pl_lwe_q [flba_pkg::NSLOT];
	logic [IDX_W-1:0] pl_la_q  [flba_pkg::NSLOT];
	logic [LEN_W-1:0] pl_ld_q  [flba_pkg::NSLOT];
	logic             pl_nwe_q [flba_pkg::NSLOT];
	logic [IDX_W-1:0] pl_na_q  [flba_pkg::NSLOT];
	logic [LEN_W-1:0] pl_nd_q  [flba_pkg::NSLOT];
	logic             pl_hwe_q [flba_pkg::NSLOT];
	logic [LEN_W-1:0] pl_hd_q  [flba_pkg::NSLOT];
	logic             pl_lwe   [flba_pkg::NSLOT];
	logic [IDX_W-1:0] pl_la    [flba_pkg::NSLOT];
	logic [LEN_W-1:0] pl_ld    [flba_pkg::NSLOT];
	logic             pl_nwe   [flba_pkg::NSLOT];
	logic [IDX_W-1:0] pl_na    [flba_pkg::NSLOT];
	logic [LEN_W-1:0] pl_nd    [flba_pkg::NSLOT];
	logic             pl_hwe   [flba_pkg::NSLOT];
	logic [LEN_W-1:0] pl_hd    [flba_pkg::NSLOT];
	logic [SL_W-1:0]  slot_q;

	// Output register
	logic                          out_valid_q;
	logic [flba_pkg::START_W-1:0]  out_start_q;
	logic [flba_pkg::STAT_W-1:0]   out_status_q;

	// Memory ports
	logic             len_we, nxt_we, ram_re;
	logic [IDX_W-1:0] len_wa, nxt_wa, ram_ra;
	logic [LEN_W-1:0] len_wd, nxt_wd, rd_len, rd_nxt;

	logic [AW-1:0] len_a, n_a, cur_a, b_a;
	logic          alloc_hit, better;
	logic [P_W-1:0] prod_a;
	logic [Q_W-1:0] prod_b;
	logic [X_W-1:0] rem_b, n_b;

	function automatic logic [LEN_W-1:0] sat(input logic [LEN_W-1:0] a,
			input logic [LEN_W-1:0] b);
		logic [AW-1:0] s;
		s = AW'(a) + AW'(b);
		return (s > POOL_A) ? POOL_L : LEN_W'(s);
	endfunction

	flba_ram #(.WIDTH(LEN_W), .DEPTH(POOL_BLOCKS)) u_len (
		.clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd),
		.re(ram_re), .raddr(ram_ra), .rdata(rd_len)
	);

	flba_ram #(.WIDTH(LEN_W), .DEPTH(POOL_BLOCKS)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.re(ram_re), .raddr(ram_ra), .rdata(rd_nxt)
	);

	// Memory read and write selection
	always_comb begin
		ram_re = cmd.rd | cmd.rd_b;
		ram_ra = cmd.rd_b ? IDX_W'(rel_q) : IDX_W'(cur_q);
		if (cmd.init) begin
			len_we = 1'b1;
			len_wa = '0;
			len_wd = POOL_L;
			nxt_we = 1'b1;
			nxt_wa = '0;
			nxt_wd = POOL_L;
		end else begin
			len_we = cmd.wr & pl_lwe_q[slot_q];
			len_wa = pl_la_q[slot_q];
			len_wd = pl_ld_q[slot_q];
			nxt_we = cmd.wr & pl_nwe_q[slot_q];
			nxt_wa = pl_na_q[slot_q];
			nxt_wd = pl_nd_q[slot_q];
		end
	end

	// Size arithmetic: reciprocal estimate, then one correction
	assign prod_a = P_W'(x_q) * P_W'(RECIP);
	assign prod_b = Q_W'(q0_s1) * Q_W'(BLOCK_BYTES);
	assign rem_b  = x_q - X_W'(prod_b);
	assign n_b    = (AW'(rem_b) >= AW'(BLOCK_BYTES)) ? q0_s1 + X_W'(1) : q0_s1;

	// Walk compares
	assign len_a     = AW'(rd_len);
	assign n_a       = AW'(n_q);
	assign cur_a     = AW'(cur_q);
	assign b_a       = AW'(rel_q);
	assign alloc_hit = (len_a >= n_a) && ((len_a == n_a) || (fit_policy == flba_pkg::POL_FIRST));
	assign better    = (len_a >= n_a) && !alloc_hit &&
		(!found_q || (AW'(sel_len_q) > len_a));

	always_comb begin
		sts.is_free   = (act_q == flba_pkg::ACT_FREE);
		sts.b_out     = (b_a >= POOL_A);
		sts.walk_go   = (cur_a < POOL_A) && (AW'(steps_q) < POOL_A);
		sts.hit       = (act_q == flba_pkg::ACT_FREE) ? (cur_a == b_a) : alloc_hit;
		sts.stop      = (cur_a > b_a);
		sts.last_slot = (slot_q == SL_W'(flba_pkg::NSLOT - 1));
		sts.out_free  = !out_valid_q || out_ready;
	end

	// Build the update plan for the finished walk
	always_comb begin
		logic [AW-1:0]    rest;
		logic             split, left, right;
		logic [LEN_W-1:0] blen, rest_l;
		for (int i = 0; i < flba_pkg::NSLOT; i++) begin
			pl_lwe[i] = 1'b0; pl_la[i] = '0; pl_ld[i] = '0;
			pl_nwe[i] = 1'b0; pl_na[i] = '0; pl_nd[i] = '0;
			pl_hwe[i] = 1'b0; pl_hd[i] = '0;
		end
		rest   = AW'(sel_cur_q) + n_a;
		rest_l = LEN_W'(rest);
		split  = !((AW'(sel_len_q) == n_a) || (rest >= POOL_A));
		blen   = rd_len;
		left   = hp_q && ((AW'(prev_q) + AW'(plen_q)) == b_a);
		right  = hasnx_q && ((b_a + AW'(blen)) == cur_a);
		if (act_q == flba_pkg::ACT_ALLOC) begin
			if (found_q) begin
				if (split) begin
					pl_lwe[0] = 1'b1; pl_la[0] = IDX_W'(rest);
					pl_ld[0] = sel_len_q - LEN_W'(n_q);
					pl_nwe[0] = 1'b1; pl_na[0] = IDX_W'(rest); pl_nd[0] = sel_nxt_q;
					pl_lwe[1] = 1'b1; pl_la[1] = IDX_W'(sel_cur_q); pl_ld[1] = LEN_W'(n_q);
					pl_nwe[1] = sel_hp_q; pl_na[1] = IDX_W'(sel_prev_q); pl_nd[1] = rest_l;
					pl_hwe[1] = !sel_hp_q; pl_hd[1] = rest_l;
				end else begin
					pl_nwe[0] = sel_hp_q; pl_na[0] = IDX_W'(sel_prev_q); pl_nd[0] = sel_nxt_q;
					pl_hwe[0] = !sel_hp_q; pl_hd[0] = sel_nxt_q;
				end
			end
		end else if (left && right) begin
			pl_lwe[0] = 1'b1; pl_la[0] = IDX_W'(prev_q);
			pl_ld[0] = sat(plen_q, sat(blen, curlen_q));
			pl_nwe[0] = 1'b1; pl_na[0] = IDX_W'(prev_q); pl_nd[0] = curnxt_q;
			pl_lwe[1] = 1'b1; pl_la[1] = IDX_W'(rel_q);
			pl_lwe[2] = 1'b1; pl_la[2] = IDX_W'(cur_q);
		end else if (left) begin
			pl_lwe[0] = 1'b1; pl_la[0] = IDX_W'(prev_q); pl_ld[0] = sat(plen_q, blen);
			pl_lwe[1] = 1'b1; pl_la[1] = IDX_W'(rel_q);
		end else if (right) begin
			pl_lwe[0] = 1'b1; pl_la[0] = IDX_W'(rel_q); pl_ld[0] = sat(blen, curlen_q);
			pl_nwe[0] = 1'b1; pl_na[0] = IDX_W'(rel_q); pl_nd[0] = curnxt_q;
			pl_lwe[1] = 1'b1; pl_la[1] = IDX_W'(cur_q);
			pl_nwe[1] = hp_q; pl_na[1] = IDX_W'(prev_q); pl_nd[1] = LEN_W'(rel_q);
			pl_hwe[1] = !hp_q; pl_hd[1] = LEN_W'(rel_q);
		end else begin
			pl_nwe[0] = 1'b1; pl_na[0] = IDX_W'(rel_q);
			pl_nd[0] = hasnx_q ? cur_q : POOL_L;
			pl_nwe[1] = hp_q; pl_na[1] = IDX_W'(prev_q); pl_nd[1] = LEN_W'(rel_q);
			pl_hwe[1] = !hp_q; pl_hd[1] = LEN_W'(rel_q);
		end
	end

	// Latch the plan
	always_ff @(posedge clk) begin
		if (cmd.plan) begin
			for (int i = 0; i < flba_pkg::NSLOT; i++) begin
				pl_lwe_q[i] <= pl_lwe[i]; pl_la_q[i] <= pl_la[i]; pl_ld_q[i] <= pl_ld[i];
				pl_nwe_q[i] <= pl_nwe[i]; pl_na_q[i] <= pl_na[i]; pl_nd_q[i] <= pl_nd[i];
				pl_hwe_q[i] <= pl_hwe[i]; pl_hd_q[i] <= pl_hd[i];
			end
		end
	end

	// Request, size and walk payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			rel_q <= in_release;
			x_q   <= X_W'(in_bytes) + X_W'(HEADER_BYTES) + X_W'(BLOCK_BYTES - 1);
			cur_q <= head_q;
		end
		if (cmd.size_a) begin
			q0_s1 <= X_W'(prod_a >> K);
		end
		if (cmd.size_b) begin
			n_q <= (n_b == '0) ? X_W'(1) : n_b;
		end
		if (cmd.eval) begin
			curlen_q <= rd_len;
			curnxt_q <= rd_nxt;
			if (act_q == flba_pkg::ACT_ALLOC && (alloc_hit || better)) begin
				sel_cur_q  <= cur_q;
				sel_prev_q <= prev_q;
				sel_hp_q   <= hp_q;
				sel_len_q  <= rd_len;
				sel_nxt_q  <= rd_nxt;
			end
			if (!(act_q == flba_pkg::ACT_FREE && (cur_a >= b_a))) begin
				prev_q <= cur_q;
				plen_q <= rd_len;
				cur_q  <= rd_nxt;
			end
		end
	end

	// Walk control flags and list head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			steps_q <= '0;
			hp_q    <= 1'b0;
			hasnx_q <= 1'b0;
			found_q <= 1'b0;
			slot_q  <= '0;
		end else begin
			if (cmd.load) begin
				steps_q <= '0;
				hp_q    <= 1'b0;
				hasnx_q <= 1'b0;
				found_q <= 1'b0;
			end
			if (cmd.eval) begin
				if (act_q == flba_pkg::ACT_ALLOC && (alloc_hit || better)) begin
					found_q <= 1'b1;
				end
				if (act_q == flba_pkg::ACT_FREE && cur_a > b_a) begin
					hasnx_q <= 1'b1;
				end else if (!(act_q == flba_pkg::ACT_FREE && cur_a == b_a)) begin
					hp_q    <= 1'b1;
					steps_q <= steps_q + LEN_W'(1);
				end
			end
			if (cmd.plan) begin
				slot_q <= '0;
			end
			if (cmd.wr) begin
				if (pl_hwe_q[slot_q]) begin
					head_q <= pl_hd_q[slot_q];
				end
				slot_q <= slot_q + SL_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result) begin
			if (act_q == flba_pkg::ACT_FREE) begin
				out_start_q  <= '0;
				out_status_q <= flba_pkg::ST_FREED;
			end else if (found_q) begin
				out_start_q  <= flba_pkg::START_W'(sel_cur_q);
				out_status_q <= flba_pkg::ST_ALLOC;
			end else begin
				out_start_q  <= '0;
				out_status_q <= flba_pkg::ST_NOSPACE;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_start  = out_start_q;
	assign out_status = out_status_q;

	// Checks
	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		AW'(steps_q) <= POOL_A)
		else $error("walk step count passed pool size");
	a_sel_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && cmd.plan && act_q == flba_pkg::ACT_ALLOC) |-> AW'(sel_len_q) >= n_a)
		else $error("chosen area smaller than request");
	a_sel_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && cmd.plan && act_q == flba_pkg::ACT_ALLOC) |-> AW'(sel_cur_q) < POOL_A)
		else $error("chosen area outside pool");
	a_wr_no_init: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr && cmd.init))
		else $error("plan write during init");

endmodule

### rtl/core/flba_ctrl.sv
module flba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  flba_pkg::sts_t sts,
	output flba_pkg::cmd_t cmd
);

	flba_pkg::state_t state_q, state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			flba_pkg::S_INIT:   state_d = flba_pkg::S_IDLE;
			flba_pkg::S_IDLE:   if (in_valid) state_d = flba_pkg::S_CHK;
			flba_pkg::S_CHK: begin
				if (!sts.is_free) state_d = flba_pkg::S_SIZE_A;
				else if (sts.b_out) state_d = flba_pkg::S_DONE;
				else state_d = flba_pkg::S_RD;
			end
			flba_pkg::S_SIZE_A: state_d = flba_pkg::S_SIZE_B;
			flba_pkg::S_SIZE_B: state_d = flba_pkg::S_RD;
			flba_pkg::S_RD: begin
				if (sts.walk_go) state_d = flba_pkg::S_EVAL;
				else if (sts.is_free) state_d = flba_pkg::S_RD_B;
				else state_d = flba_pkg::S_PLAN;
			end
			flba_pkg::S_EVAL: begin
				if (!sts.is_free) begin
					state_d = sts.hit ? flba_pkg::S_PLAN : flba_pkg::S_RD;
				end else if (sts.hit) begin
					state_d = flba_pkg::S_DONE;
				end else if (sts.stop) begin
					state_d = flba_pkg::S_RD_B;
				end else begin
					state_d = flba_pkg::S_RD;
				end
			end
			flba_pkg::S_RD_B:   state_d = flba_pkg::S_PLAN;
			flba_pkg::S_PLAN:   state_d = flba_pkg::S_WR;
			flba_pkg::S_WR:     if (sts.last_slot) state_d = flba_pkg::S_DONE;
			flba_pkg::S_DONE:   if (sts.out_free) state_d = flba_pkg::S_IDLE;
			default:            state_d = flba_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			flba_pkg::S_INIT:   cmd.init = 1'b1;
			flba_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			flba_pkg::S_SIZE_A: cmd.size_a = 1'b1;
			flba_pkg::S_SIZE_B: cmd.size_b = 1'b1;
			flba_pkg::S_RD:     cmd.rd = sts.walk_go;
			flba_pkg::S_EVAL:   cmd.eval = 1'b1;
			flba_pkg::S_RD_B:   cmd.rd_b = 1'b1;
			flba_pkg::S_PLAN:   cmd.plan = 1'b1;
			flba_pkg::S_WR:     cmd.wr = 1'b1;
			flba_pkg::S_DONE:   cmd.result = sts.out_free;
			default:            cmd = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flba_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Checks
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == flba_pkg::S_CHK)
		else $error("request load did not start decode");
	a_eval_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == flba_pkg::S_EVAL |-> $past(cmd.rd))
		else $error("evaluation without a list read");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |=> state_q == flba_pkg::S_IDLE)
		else $error("result issued without return to idle");

endmodule

### verif/free_list_block_allocator_checker.sv
module free_list_block_allocator_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // request_bytes[12:0], release_block[20:13], zero pad
	input  logic        s_axis_tuser,   // action
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,   // start_block[7:0]
	input  logic [1:0]  m_axis_tuser,   // status[1:0]
	output int          fail_count,
	output int          pending,
	output int          n_alloc,
	output int          n_nospace,
	output int          n_freed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = flba_pkg::POOL_BLOCKS_DEF;

	typedef struct packed {
		logic [flba_pkg::START_W-1:0] start;
		logic [flba_pkg::STAT_W-1:0]  status;
	} grant_t;

	int unsigned len_mem [NB];
	int unsigned link_mem [NB];
	int unsigned head;
	logic        policy;
	grant_t      grant_q[$];

	function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
		int unsigned s;
		s = a + b;
		return (s > NB) ? NB : s;
	endfunction

	function automatic void relink(bit has_prev, int unsigned prev, int unsigned tgt);
		if (has_prev) link_mem[prev] = tgt;
		else head = tgt;
	endfunction

	function automatic void carve(bit has_prev, int unsigned prev, int unsigned cur,
			int unsigned n);
		int unsigned l;
		int unsigned rest;
		l = len_mem[cur];
		rest = cur + n;
		if (l == n || rest >= NB) begin
			relink(has_prev, prev, link_mem[cur]);
			return;
		end
		len_mem[rest] = l - n;
		link_mem[rest] = link_mem[cur];
		relink(has_prev, prev, rest);
		len_mem[cur] = n;
	endfunction

	// Walk the list and pick an area by the current fit policy
	function automatic grant_t allocate_area(int unsigned bytes);
		int unsigned n, prev, cur, steps, best, best_prev, l;
		bit has_prev, found, best_hp;
		grant_t g;
		n = (bytes + flba_pkg::HEADER_BYTES_DEF + flba_pkg::BLOCK_BYTES_DEF - 1)
			/ flba_pkg::BLOCK_BYTES_DEF;
		if (n == 0) n = 1;
		has_prev = 0; found = 0; best_hp = 0;
		prev = 0; cur = head; steps = 0; best = 0; best_prev = 0;
		while (cur < NB && steps < NB) begin
			l = len_mem[cur];
			if (l >= n) begin
				if (l == n || policy == flba_pkg::POL_FIRST) begin
					carve(has_prev, prev, cur, n);
					g.start = cur[7:0];
					g.status = flba_pkg::ST_ALLOC;
					return g;
				end
				if (!found || len_mem[best] > l) begin
					found = 1; best = cur; best_prev = prev; best_hp = has_prev;
				end
			end
			prev = cur;
			has_prev = 1;
			cur = link_mem[cur];
			steps++;
		end
		if (found) begin
			carve(best_hp, best_prev, best, n);
			g.start = best[7:0];
			g.status = flba_pkg::ST_ALLOC;
			return g;
		end
		g.start = '0;
		g.status = flba_pkg::ST_NOSPACE;
		return g;
	endfunction

	// Insert in address order and merge with neighbors
	function automatic void release_area(int unsigned b);
		int unsigned p, cur, steps, bl;
		bit has_prev, has_next, lft, rgt;
		has_prev = 0; p = 0; cur = head; steps = 0;
		if (b >= NB) return;
		while (cur < NB && steps < NB && cur <= b) begin
			if (cur == b) return;
			p = cur;
			has_prev = 1;
			cur = link_mem[cur];
			steps++;
		end
		has_next = cur < NB && steps < NB;
		bl = len_mem[b];
		lft = has_prev && (p + len_mem[p] == b);
		rgt = has_next && (b + bl == cur);
		if (lft && rgt) begin
			len_mem[p] = sat_sum(len_mem[p], sat_sum(bl, len_mem[cur]));
			link_mem[p] = link_mem[cur];
			len_mem[b] = 0;
			len_mem[cur] = 0;
		end else if (lft) begin
			len_mem[p] = sat_sum(len_mem[p], bl);
			len_mem[b] = 0;
		end else if (rgt) begin
			len_mem[b] = sat_sum(bl, len_mem[cur]);
			link_mem[b] = link_mem[cur];
			len_mem[cur] = 0;
			relink(has_prev, p, b);
		end else begin
			link_mem[b] = has_next ? cur : NB;
			relink(has_prev, p, b);
		end
	endfunction

	assign pending = grant_q.size();

	// Track requests, config writes and grants
	always @(posedge clk or negedge arst_n) begin
		grant_t g;
		grant_t want;
		if (!arst_n) begin
			foreach (len_mem[i]) begin
				len_mem[i] = 0;
				link_mem[i] = 0;
			end
			len_mem[0] = NB;
			link_mem[0] = NB;
			head = 0;
			policy = flba_pkg::POL_FIRST;
			grant_q.delete();
			fail_count <= 0;
			n_alloc <= 0;
			n_nospace <= 0;
			n_freed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) policy = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == flba_pkg::ACT_ALLOC) begin
					g = allocate_area(s_axis_tdata[flba_pkg::BYTES_W-1:0]);
				end else begin
					release_area(s_axis_tdata[flba_pkg::BYTES_W +: flba_pkg::REL_W]);
					g.start = '0;
					g.status = flba_pkg::ST_FREED;
				end
				grant_q.push_back(g);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (grant_q.size() == 0) begin
					$display("%0t: unexpected result start=%0d status=%0d", $time,
						m_axis_tdata, m_axis_tuser);
					fail_count <= fail_count + 1;
				end else begin
					want = grant_q.pop_front();
					if (want.start !== m_axis_tdata || want.status !== m_axis_tuser) begin
						$display("%0t: mismatch expected start=%0d status=%0d, got start=%0d status=%0d",
							$time, want.start, want.status, m_axis_tdata, m_axis_tuser);
						fail_count <= fail_count + 1;
					end
					case (want.status)
						flba_pkg::ST_ALLOC:   n_alloc <= n_alloc + 1;
						flba_pkg::ST_NOSPACE: n_nospace <= n_nospace + 1;
						default:              n_freed <= n_freed + 1;
					endcase
				end
			end
		end
	end

endmodule

### verif/free_list_block_allocator_core_tb.sv
module free_list_block_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 5_000_000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // request_bytes[12:0], release_block[20:13], zero pad
	logic        s_axis_tuser;   // action
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // start_block[7:0]
	logic [1:0]  m_axis_tuser;   // status[1:0]
	int          fail_count, pending, n_alloc, n_nospace, n_freed;
	longint      cycles = 0;
	int unsigned rdy_wait;

	// Start blocks of areas currently held by the test
	int unsigned held_q[$];
	int unsigned open_q[$];

	free_list_block_allocator_core u_top (.*);

	free_list_block_allocator_checker u_chk (.*);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stall each grant by holding tready low for a random wait
	always @(posedge clk or negedge arst_n) begin
		int unsigned w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rdy_wait <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			w = $urandom_range(0, 5);
			rdy_wait <= w;
			m_axis_tready <= (w == 0);
		end else if (m_axis_tvalid) begin
			if (rdy_wait == 0) m_axis_tready <= 1'b1;
			else rdy_wait <= rdy_wait - 1;
		end
	end

	// Record grants so their areas can be released later
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready && m_axis_tuser == flba_pkg::ST_ALLOC)
			open_q.push_back(m_axis_tdata);
	end

	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 5);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_request(logic act, int unsigned bytes, int unsigned rel);
		idle_gap();
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {3'b0, rel[flba_pkg::REL_W-1:0], bytes[flba_pkg::BYTES_W-1:0]};
		do @(posedge clk); while (!s_axis_tready);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic set_policy(logic p);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= p;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic release_held(int idx);
		int unsigned b;
		b = held_q[idx];
		held_q.delete(idx);
		send_request(flba_pkg::ACT_FREE, 0, b);
	endtask

	task automatic burst(int count);
		int unsigned bytes;
		int k;
		for (k = 0; k < count; k++) begin
			while (open_q.size() != 0) held_q.push_back(open_q.pop_front());
			case ($urandom_range(0, 9))
				// Zero-byte request with junk in the release field
				0: send_request(flba_pkg::ACT_ALLOC, 0, $urandom_range(0, 255));
				1, 2, 3, 4: begin
					if (held_q.size() != 0) release_held($urandom_range(0, held_q.size() - 1));
					else send_request(flba_pkg::ACT_ALLOC, 0, $urandom_range(0, 255));
				end
				default: begin
					bytes = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191)
						: $urandom_range(0, 200);
					send_request(flba_pkg::ACT_ALLOC, bytes, $urandom_range(0, 255));
				end
			endcase
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = flba_pkg::POL_FIRST;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = flba_pkg::ACT_ALLOC;
		s_axis_tdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero-size, header-only, huge, exact fills, frees and merges
		send_request(flba_pkg::ACT_ALLOC, 0, 0);
		send_request(flba_pkg::ACT_ALLOC, 8, 255);
		send_request(flba_pkg::ACT_ALLOC, 9, 0);
		send_request(flba_pkg::ACT_ALLOC, 4096, 0);
		send_request(flba_pkg::ACT_ALLOC, 8191, 0);
		// Release of the start of an area that is already free
		send_request(flba_pkg::ACT_FREE, 8191, 4);
		drain();
		while (open_q.size() != 0) held_q.push_back(open_q.pop_front());
		send_request(flba_pkg::ACT_FREE, 0, 1);
		send_request(flba_pkg::ACT_FREE, 0, 1);
		send_request(flba_pkg::ACT_FREE, 0, 0);
		send_request(flba_pkg::ACT_FREE, 0, 2);
		drain();
		held_q.delete();
		open_q.delete();
		send_request(flba_pkg::ACT_ALLOC, 4088, 0);
		send_request(flba_pkg::ACT_ALLOC, 0, 0);
		drain();
		while (open_q.size() != 0) held_q.push_back(open_q.pop_front());
		while (held_q.size() != 0) release_held(0);

		// Best fit over a fragmented pool
		set_policy(flba_pkg::POL_BEST);
		for (i = 0; i < 6; i++) send_request(flba_pkg::ACT_ALLOC, 16 * (i + 1) + 8, 0);
		drain();
		while (open_q.size() != 0) held_q.push_back(open_q.pop_front());
		release_held(1);
		release_held(2);
		send_request(flba_pkg::ACT_ALLOC, 24, 0);
		send_request(flba_pkg::ACT_ALLOC, 100, 0);

		// Random phases across both policies
		set_policy(flba_pkg::POL_FIRST);
		burst(450);
		set_policy(flba_pkg::POL_BEST);
		burst(450);
		set_policy(flba_pkg::POL_FIRST);
		burst(450);
		set_policy(flba_pkg::POL_BEST);
		burst(450);

		drain();
		$display("Covered %0d grants, %0d out-of-space replies and %0d releases",
			n_alloc, n_nospace, n_freed);
		$display("under first fit and best fit with random stalls on both channels");
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/flba_pkg.sv
rtl/core/flba_ram.sv
rtl/core/flba_dp.sv
rtl/core/flba_ctrl.sv
rtl/core/free_list_block_allocator_core.sv
verif/free_list_block_allocator_checker.sv
verif/free_list_block_allocator_core_tb.sv
